/* src/hsd_pkg.sv */
`default_nettype none
package hsd_pkg;

	// field widths
	localparam int CELL_W = 8;
	localparam int RES_W  = 4;

	// internal coordinate width, sized for the largest spiral the block supports
	localparam int CRD_W = 8;

	localparam int NUM_CELLS_DEF = 128;

	// walk direction codes, zero before the first corner
	localparam logic [2:0] DIR_NONE = 3'd0;
	localparam logic [2:0] DIR_1    = 3'd1;
	localparam logic [2:0] DIR_2    = 3'd2;
	localparam logic [2:0] DIR_3    = 3'd3;
	localparam logic [2:0] DIR_4    = 3'd4;
	localparam logic [2:0] DIR_5    = 3'd5;
	localparam logic [2:0] DIR_6    = 3'd6;

	typedef logic [2:0] dir_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_a;
		logic [CELL_W-1:0] cell_b;
	} hsd_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] a_x;
		logic signed [RES_W-1:0] a_y;
		logic signed [RES_W-1:0] a_z;
		logic signed [RES_W-1:0] b_x;
		logic signed [RES_W-1:0] b_y;
		logic signed [RES_W-1:0] b_z;
		logic        [RES_W-1:0] distance;
	} hsd_out_t;

endpackage
`default_nettype wire

/* src/hex_spiral_distance.sv */
// hex_spiral_distance: two hex spiral cell numbers in, their cube coordinates
// and the hex distance between them out.
//
// Input: raise start with both cell numbers on cells while busy is low; the
// beat is taken at that edge and busy goes high on the next cycle.
// A cell number of zero reads as the origin, one above NUM_CELLS as NUM_CELLS.
// Output: done is high for exactly one cycle with the result on result;
// the receiver must take it then, there is no way to hold it off.
//
// Timing: one step unit walks the spiral a cell per cycle from cell 1 up to
// the larger of the two cell numbers, snapping each coordinate as it passes.
// busy drops in the cycle that done is high, so a new beat can be taken
// right after it; no new beat is taken while a walk or distance step runs.
//
// Reset: arst_n low clears the sequencer to idle with done low; nothing else
// needs to be cleared.
`default_nettype none
module hex_spiral_distance #(
	parameter int NUM_CELLS = hsd_pkg::NUM_CELLS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire hsd_pkg::hsd_in_t  cells,
	output logic                 done,
	output hsd_pkg::hsd_out_t    result
);
	import hsd_pkg::*;

	localparam int CNT_W = $clog2(NUM_CELLS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DIST = 3'b100
	} state_t;

	typedef logic signed [CRD_W-1:0] crd_t;

	state_t             state_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   tgt_a_q, tgt_b_q, last_q;
	crd_t               x_q, y_q, z_q, ring_q;
	dir_t               dir_q;
	crd_t               ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic               done_q;
	hsd_out_t           result_q;

	logic [CNT_W-1:0]   tgt_a, tgt_b;
	crd_t               x_n, y_n, z_n, ring_n;
	dir_t               dir_n, corner;
	logic               accept;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// clamp one cell number into 1..NUM_CELLS
	function automatic logic [CNT_W-1:0] clamp_cell(input logic [CELL_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (int'(c) > NUM_CELLS) begin
			r = CNT_W'(NUM_CELLS);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

	assign tgt_a = clamp_cell(cells.cell_a);
	assign tgt_b = clamp_cell(cells.cell_b);

	// corner detect on the current cell
	always_comb begin
		corner = DIR_NONE;
		if (x_q == 0 && y_q < 0 && z_q > 0) begin
			corner = DIR_1;
		end else if (y_q == 0 && x_q < 0 && z_q > 0) begin
			corner = DIR_2;
		end else if (z_q == 0 && x_q < 0 && y_q > 0) begin
			corner = DIR_3;
		end else if (x_q == 0 && y_q > 0 && z_q < 0) begin
			corner = DIR_4;
		end else if (y_q == 0 && x_q > 0 && z_q < 0) begin
			corner = DIR_5;
		end else if (z_q == 0 && x_q > 0 && y_q < 0) begin
			corner = DIR_6;
		end
	end

	// shared step unit: next cell of the spiral
	always_comb begin
		x_n    = x_q;
		y_n    = y_q;
		z_n    = z_q;
		ring_n = ring_q;
		dir_n  = dir_q;
		if (idx_q == CNT_W'(1)) begin
			x_n = crd_t'(0);
			y_n = crd_t'(-1);
			z_n = crd_t'(1);
		end else if (corner != DIR_NONE) begin
			dir_n = corner;
			case (corner)
				DIR_1: begin
					x_n = crd_t'(-1); y_n = crd_t'(1) - ring_q; z_n = ring_q;
				end
				DIR_2: begin
					x_n = -ring_q; y_n = crd_t'(1); z_n = ring_q - crd_t'(1);
				end
				DIR_3: begin
					x_n = crd_t'(1) - ring_q; y_n = ring_q; z_n = crd_t'(-1);
				end
				DIR_4: begin
					x_n = crd_t'(1); y_n = ring_q - crd_t'(1); z_n = -ring_q;
				end
				DIR_5: begin
					x_n = ring_q; y_n = crd_t'(-1); z_n = crd_t'(1) - ring_q;
				end
				default: begin
					x_n    = ring_q;
					y_n    = -ring_q - crd_t'(1);
					z_n    = crd_t'(1);
					ring_n = ring_q + crd_t'(1);
				end
			endcase
		end else begin
			case (dir_q)
				DIR_6: begin x_n = x_q - crd_t'(1); z_n = z_q + crd_t'(1); end
				DIR_1: begin x_n = x_q - crd_t'(1); y_n = y_q + crd_t'(1); end
				DIR_2: begin y_n = y_q + crd_t'(1); z_n = z_q - crd_t'(1); end
				DIR_3: begin x_n = x_q + crd_t'(1); z_n = z_q - crd_t'(1); end
				DIR_4: begin x_n = x_q + crd_t'(1); y_n = y_q - crd_t'(1); end
				DIR_5: begin y_n = y_q - crd_t'(1); z_n = z_q + crd_t'(1); end
				default: begin end
			endcase
		end
	end

	// distance from the two captured triples
	logic signed [CRD_W:0]   dx, dy, dz;
	logic        [CRD_W+2:0] dsum;
	always_comb begin
		dx = (CRD_W+1)'(ax_q) - (CRD_W+1)'(bx_q);
		dy = (CRD_W+1)'(ay_q) - (CRD_W+1)'(by_q);
		dz = (CRD_W+1)'(az_q) - (CRD_W+1)'(bz_q);
		dsum = (CRD_W+3)'(unsigned'(dx < 0 ? -dx : dx))
		     + (CRD_W+3)'(unsigned'(dy < 0 ? -dy : dy))
		     + (CRD_W+3)'(unsigned'(dz < 0 ? -dz : dz));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (idx_q == last_q) begin
						state_q <= ST_DIST;
					end
				end
				ST_DIST: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_a_q <= tgt_a;
			tgt_b_q <= tgt_b;
			last_q  <= (tgt_a > tgt_b) ? tgt_a : tgt_b;
			idx_q   <= CNT_W'(1);
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			ring_q  <= crd_t'(1);
			dir_q   <= DIR_NONE;
		end else if (state_q == ST_WALK) begin
			if (idx_q == tgt_a_q) begin
				ax_q <= x_q; ay_q <= y_q; az_q <= z_q;
			end
			if (idx_q == tgt_b_q) begin
				bx_q <= x_q; by_q <= y_q; bz_q <= z_q;
			end
			if (idx_q != last_q) begin
				x_q    <= x_n;
				y_q    <= y_n;
				z_q    <= z_n;
				ring_q <= ring_n;
				dir_q  <= dir_n;
				idx_q  <= idx_q + CNT_W'(1);
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (state_q == ST_DIST) begin
			result_q.a_x      <= ax_q[RES_W-1:0];
			result_q.a_y      <= ay_q[RES_W-1:0];
			result_q.a_z      <= az_q[RES_W-1:0];
			result_q.b_x      <= bx_q[RES_W-1:0];
			result_q.b_y      <= by_q[RES_W-1:0];
			result_q.b_z      <= bz_q[RES_W-1:0];
			result_q.distance <= dsum[RES_W:1];
		end
	end

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_from_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q == ST_DIST) && !busy))
		else $error("done without finishing distance step");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q <= last_q))
		else $error("walk index ran past its last cell");

	a_cube_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> ((x_q + y_q + z_q) == crd_t'(0)))
		else $error("cube coordinates left the plane");

endmodule
`default_nettype wire

/* bench/hex_spiral_distance_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module hex_spiral_distance_tb;
	import hsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = NUM_CELLS_DEF + 20;
	localparam int RANDOM_ITEMS   = 400;

	typedef struct {
		int x;
		int y;
		int z;
	} cube_pos_t;

	// expected results and the checks against them
	class spiral_checker;
		hsd_out_t coord_q[$];
		int unsigned mismatch_cnt;

		function new();
			mismatch_cnt = 0;
		endfunction

		// walk the spiral from the origin to the given cell
		function cube_pos_t spiral_coord(int unsigned cell_num);
			cube_pos_t p;
			int ring;
			dir_t heading;
			dir_t corner;
			p = '{0, 0, 0};
			ring = 1;
			heading = DIR_NONE;
			if (cell_num == 0) cell_num = 1;
			if (cell_num > NUM_CELLS_DEF) cell_num = NUM_CELLS_DEF;
			if (cell_num == 1) return p;
			p = '{0, -1, 1};
			for (int unsigned i = 3; i <= cell_num; i++) begin
				// which corner, if any, the last cell sits on
				if (p.x == 0 && p.y < 0 && p.z > 0) corner = DIR_1;
				else if (p.y == 0 && p.x < 0 && p.z > 0) corner = DIR_2;
				else if (p.z == 0 && p.x < 0 && p.y > 0) corner = DIR_3;
				else if (p.x == 0 && p.y > 0 && p.z < 0) corner = DIR_4;
				else if (p.y == 0 && p.x > 0 && p.z < 0) corner = DIR_5;
				else if (p.z == 0 && p.x > 0 && p.y < 0) corner = DIR_6;
				else corner = DIR_NONE;
				if (corner != DIR_NONE) begin
					// turn at the corner, the sixth one opens the next ring
					heading = corner;
					case (corner)
						DIR_1: p = '{-1, 1 - ring, ring};
						DIR_2: p = '{-ring, 1, ring - 1};
						DIR_3: p = '{1 - ring, ring, -1};
						DIR_4: p = '{1, ring - 1, -ring};
						DIR_5: p = '{ring, -1, 1 - ring};
						default: begin
							p = '{ring, -ring - 1, 1};
							ring++;
						end
					endcase
				end else begin
					// straight step along the current side
					case (heading)
						DIR_6: begin p.x -= 1; p.z += 1; end
						DIR_1: begin p.x -= 1; p.y += 1; end
						DIR_2: begin p.y += 1; p.z -= 1; end
						DIR_3: begin p.x += 1; p.z -= 1; end
						DIR_4: begin p.x += 1; p.y -= 1; end
						DIR_5: begin p.y -= 1; p.z += 1; end
						default: ;
					endcase
				end
			end
			return p;
		endfunction

		// predict the result of an accepted input beat
		function void note_cells(hsd_in_t v);
			cube_pos_t pa;
			cube_pos_t pb;
			int hex_dist;
			hsd_out_t e;
			pa = spiral_coord(v.cell_a);
			pb = spiral_coord(v.cell_b);
			hex_dist = ((pa.x > pb.x) ? pa.x - pb.x : pb.x - pa.x)
				+ ((pa.y > pb.y) ? pa.y - pb.y : pb.y - pa.y)
				+ ((pa.z > pb.z) ? pa.z - pb.z : pb.z - pa.z);
			hex_dist = hex_dist / 2;
			e.a_x = RES_W'(pa.x);
			e.a_y = RES_W'(pa.y);
			e.a_z = RES_W'(pa.z);
			e.b_x = RES_W'(pb.x);
			e.b_y = RES_W'(pb.y);
			e.b_z = RES_W'(pb.z);
			e.distance = RES_W'(hex_dist);
			coord_q.push_back(e);
		endfunction

		function void report(string what, logic [RES_W-1:0] want, logic [RES_W-1:0] got);
			if (want !== got) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
			end
		endfunction

		// compare a result beat with the oldest prediction
		function void check_result(hsd_out_t r);
			hsd_out_t e;
			if (coord_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result %h with nothing expected", $time, r);
				return;
			end
			e = coord_q.pop_front();
			report("a_x", e.a_x, r.a_x);
			report("a_y", e.a_y, r.a_y);
			report("a_z", e.a_z, r.a_z);
			report("b_x", e.b_x, r.b_x);
			report("b_y", e.b_y, r.b_y);
			report("b_z", e.b_z, r.b_z);
			report("distance", e.distance, r.distance);
		endfunction

		function int pending();
			return coord_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	hsd_in_t cells;
	logic done;
	hsd_out_t result;

	spiral_checker sb;
	int unsigned idle_cycles;

	hex_spiral_distance u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cells (cells),
		.done  (done),
		.result(result)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result monitor and watchdog on stalled handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(result);
			if ((start && !busy) || done) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	// hold start until the beat is taken, called at a falling edge
	task automatic send_cells(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b);
		hsd_in_t v;
		v.cell_a = a;
		v.cell_b = b;
		start <= 1'b1;
		cells <= v;
		do @(posedge clk); while (busy);
		sb.note_cells(v);
		@(negedge clk);
	endtask

	// idle between beats, mostly short
	task automatic sender_gap(input bit no_idle);
		int n;
		int pick;
		pick = $urandom_range(99);
		if (no_idle || pick < 40) n = 0;
		else if (pick < 85) n = $urandom_range(3, 1);
		else if (pick < 97) n = $urandom_range(20, 4);
		else n = $urandom_range(100, 30);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// random cell number, mostly inside the spiral
	function automatic logic [CELL_W-1:0] rand_cell();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) return '0;
		if (pick < 12) return CELL_W'($urandom_range(255, NUM_CELLS_DEF + 1));
		if (pick < 40) return CELL_W'($urandom_range(19, 1));
		return CELL_W'($urandom_range(NUM_CELLS_DEF, 1));
	endfunction

	initial begin
		bit calm;
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cells = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: origin, zero, saturation, first corners of each ring, bit patterns
		send_cells(8'd1, 8'd1);
		send_cells(8'd0, 8'd0);
		send_cells(8'd0, 8'd2);
		send_cells(8'd2, 8'd3);
		send_cells(8'd4, 8'd5);
		sender_gap(1'b0);
		send_cells(8'd6, 8'd7);
		send_cells(8'd8, 8'd19);
		send_cells(8'd20, 8'd37);
		sender_gap(1'b0);
		send_cells(8'd38, 8'd61);
		send_cells(8'd62, 8'd91);
		send_cells(8'd92, 8'd127);
		send_cells(8'd127, 8'd128);
		send_cells(8'd128, 8'd1);
		send_cells(8'd1, 8'd128);
		send_cells(8'd129, 8'd128);
		send_cells(8'd255, 8'd0);
		send_cells(8'd0, 8'd255);
		send_cells(8'haa, 8'h55);
		send_cells(8'h55, 8'haa);
		send_cells(8'h7f, 8'h80);
		send_cells(8'd110, 8'd119);

		// random part, in stretches with and without idling
		calm = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) calm = ($urandom_range(2) == 0);
			if (i == RANDOM_ITEMS / 2) begin
				// let everything drain before going on
				start <= 1'b0;
				while (sb.pending() > 0) @(negedge clk);
			end
			sender_gap(calm);
			send_cells(rand_cell(), rand_cell());
		end
		start <= 1'b0;

		// drain and watch for stray results
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_cnt == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
